FILE: rtl/rcal_pkg.sv
package rcal_pkg;

    // Field widths
    localparam int YEAR_W        = 12;
    localparam int MONTH_W       = 4;
    localparam int DOM_W         = 5;
    localparam int DOW_W         = 3;
    localparam int HOUR_W        = 5;
    localparam int MINUTE_W      = 6;
    localparam int SECOND_W      = 6;
    localparam int ALARM_FIRED_W = 4;
    localparam int ALARM_W       = 49;

    // Configuration port
    localparam int CFG_COUNT   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = ALARM_W;

    // Default number of active alarms
    localparam int NUM_ALARMS_DEF = 4;

    // Rollover limits
    localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
    localparam logic [DOW_W-1:0]    DOW_LAST    = 3'd7;
    localparam logic [DOW_W-1:0]    DOW_FIRST   = 3'd1;
    localparam logic [DOM_W-1:0]    DOM_FIRST   = 5'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W:0]    MONTH_LAST  = 5'd12;

    // Month codes with special lengths
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

    // Reset time: Thursday, 1 January 1970, 00:00:00
    localparam logic [YEAR_W-1:0]   RST_YEAR   = 12'd1970;
    localparam logic [MONTH_W-1:0]  RST_MONTH  = 4'd1;
    localparam logic [DOM_W-1:0]    RST_DOM    = 5'd1;
    localparam logic [DOW_W-1:0]    RST_DOW    = 3'd5;
    localparam logic [HOUR_W-1:0]   RST_HOUR   = 5'd0;
    localparam logic [MINUTE_W-1:0] RST_MINUTE = 6'd0;
    localparam logic [SECOND_W-1:0] RST_SECOND = 6'd0;

    // Divisibility by 25 on a 12-bit year: multiply by the inverse of 25
    // modulo 4096; multiples of 25 land at or below 4095/25.
    localparam logic [YEAR_W-1:0] INV25     = 12'd3113;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 12'd163;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_SET  = 1'b1
    } func_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DOM_W-1:0]    day_of_month;
        logic [DOW_W-1:0]    day_of_week;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } cal_time_t;

    typedef struct packed {
        func_t               func;
        logic [YEAR_W-1:0]   set_year;
        logic [MONTH_W-1:0]  set_month;
        logic [DOM_W-1:0]    set_day_of_month;
        logic [DOW_W-1:0]    set_day_of_week;
        logic [HOUR_W-1:0]   set_hour;
        logic [MINUTE_W-1:0] set_minute;
        logic [SECOND_W-1:0] set_second;
    } in_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]        year;
        logic [MONTH_W-1:0]       month;
        logic [DOM_W-1:0]         day_of_month;
        logic [DOW_W-1:0]         day_of_week;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [SECOND_W-1:0]      second;
        logic [ALARM_FIRED_W-1:0] alarm_fired;
    } out_item_t;

    // Packed alarm word, bit 48 down to bit 0
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DOM_W-1:0]    day_of_month;
        logic [DOW_W-1:0]    day_of_week;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic                wild_year;
        logic                wild_month;
        logic                wild_day_of_month;
        logic                wild_day_of_week;
        logic                wild_hour;
        logic                wild_minute;
        logic                wild_second;
        logic                enable;
    } alarm_word_t;

    // Gregorian leap rule
    function automatic logic is_leap(logic [YEAR_W-1:0] year);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = YEAR_W'(year * INV25);
        div25 = (prod <= DIV25_MAX);
        return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    endfunction

    // Month length; codes outside 1..12 count as 31 days
    function automatic logic [DOM_W-1:0] days_in(logic [MONTH_W-1:0] month, logic leap);
        logic [DOM_W-1:0] len;
        case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR: len = 5'd30;
            MONTH_JUN: len = 5'd30;
            MONTH_SEP: len = 5'd30;
            MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/rcal_if.sv
// Input channel: one tick or set item per transfer
interface rcal_in_if;
    logic               valid;
    logic               ready;
    rcal_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Output channel: one time and alarm result per transfer
interface rcal_out_if;
    logic                valid;
    logic                ready;
    rcal_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rcal_alarm_match.sv
module rcal_alarm_match (
    input  rcal_pkg::alarm_word_t word,
    input  rcal_pkg::cal_time_t   now,
    output logic                  hit
);

    logic sec_ok;
    logic min_ok;
    logic hour_ok;
    logic dow_ok;
    logic dom_ok;
    logic month_ok;
    logic year_ok;

    // Each field matches when wildcarded or equal
    assign sec_ok   = word.wild_second       || (word.second == now.second);
    assign min_ok   = word.wild_minute       || (word.minute == now.minute);
    assign hour_ok  = word.wild_hour         || (word.hour == now.hour);
    assign dow_ok   = word.wild_day_of_week  || (word.day_of_week == now.day_of_week);
    assign dom_ok   = word.wild_day_of_month || (word.day_of_month == now.day_of_month);
    assign month_ok = word.wild_month        || (word.month == now.month);
    assign year_ok  = word.wild_year         || (word.year == now.year);

    assign hit = word.enable && sec_ok && min_ok && hour_ok && dow_ok
                 && dom_ok && month_ok && year_ok;

endmodule

FILE: rtl/rcal_advance.sv
module rcal_advance (
    input  rcal_pkg::cal_time_t cur,
    output rcal_pkg::cal_time_t nxt
);

    logic                             leap;
    logic [rcal_pkg::DOM_W-1:0]       day_len;
    logic [rcal_pkg::DOM_W:0]         dom_inc;
    logic [rcal_pkg::MONTH_W:0]       month_inc;

    assign leap      = rcal_pkg::is_leap(cur.year);
    assign day_len   = rcal_pkg::days_in(cur.month, leap);
    assign dom_inc   = {1'b0, cur.day_of_month} + 6'd1;
    assign month_inc = {1'b0, cur.month} + 5'd1;

    // Ripple the one-second step through the calendar
    always_comb
    begin
        nxt = cur;
        if (cur.second < rcal_pkg::SECOND_LAST)
        begin
            nxt.second = cur.second + 6'd1;
        end
        else
        begin
            nxt.second = '0;
            if (cur.minute < rcal_pkg::MINUTE_LAST)
            begin
                nxt.minute = cur.minute + 6'd1;
            end
            else
            begin
                nxt.minute = '0;
                if (cur.hour < rcal_pkg::HOUR_LAST)
                begin
                    nxt.hour = cur.hour + 5'd1;
                end
                else
                begin
                    nxt.hour = '0;
                    // Weekday wraps from Saturday back to Sunday
                    if (cur.day_of_week == rcal_pkg::DOW_LAST)
                    begin
                        nxt.day_of_week = rcal_pkg::DOW_FIRST;
                    end
                    else
                    begin
                        nxt.day_of_week = cur.day_of_week + 3'd1;
                    end
                    // Day, month and year carries
                    if (dom_inc > {1'b0, day_len})
                    begin
                        nxt.day_of_month = rcal_pkg::DOM_FIRST;
                        if (month_inc > rcal_pkg::MONTH_LAST)
                        begin
                            nxt.month = rcal_pkg::MONTH_FIRST;
                            nxt.year  = cur.year + 12'd1;
                        end
                        else
                        begin
                            nxt.month = month_inc[rcal_pkg::MONTH_W-1:0];
                        end
                    end
                    else
                    begin
                        nxt.day_of_month = dom_inc[rcal_pkg::DOM_W-1:0];
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/calendar_second_counter_with_alarms_core.sv
// Real-time-clock calendar with up to four wildcard alarms. Every item on
// in_ch yields exactly one result on out_ch, in the cycle after its transfer.
// A tick item (func = FUNC_TICK) reports in alarm_fired which enabled alarms
// matched the time before the tick, then advances the time by one second;
// a set item loads all calendar fields, weekday included, unchecked, and
// reports no alarm. The block takes one item per cycle: the calendar step
// and the alarm compares finish in the cycle of the transfer, and a single
// output register holds the result; in_ch.ready drops only while that
// register is full and out_ch.ready is low. Alarm words are written through
// cfg_we/cfg_index/cfg_data while no item is in flight; writes to alarms at
// or beyond NUM_ALARMS are dropped and those alarms never fire. Reset time
// is Thursday 1970-01-01 00:00:00 with all alarms disabled.
module calendar_second_counter_with_alarms_core #(
    parameter int NUM_ALARMS = rcal_pkg::NUM_ALARMS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rcal_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcal_pkg::CFG_DATA_W-1:0]  cfg_data,
    rcal_in_if.sink                          in_ch,
    rcal_out_if.source                       out_ch
);

    localparam rcal_pkg::cal_time_t RST_TIME = '{
        year:         rcal_pkg::RST_YEAR,
        month:        rcal_pkg::RST_MONTH,
        day_of_month: rcal_pkg::RST_DOM,
        day_of_week:  rcal_pkg::RST_DOW,
        hour:         rcal_pkg::RST_HOUR,
        minute:       rcal_pkg::RST_MINUTE,
        second:       rcal_pkg::RST_SECOND
    };

    rcal_pkg::alarm_word_t alarm_reg [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] hit;

    rcal_pkg::cal_time_t   time_reg;
    rcal_pkg::cal_time_t   time_next;
    rcal_pkg::cal_time_t   time_adv;
    rcal_pkg::out_item_t   out_data_reg;
    rcal_pkg::out_item_t   out_data_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  in_ready;
    logic                  in_xfer;
    logic [rcal_pkg::ALARM_FIRED_W-1:0] fired;

    // Alarm registers and their match units
    for (genvar i = 0; i < NUM_ALARMS; i++)
    begin : g_alarm
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                alarm_reg[i] <= '0;
            end
            else if (cfg_we && (cfg_index == rcal_pkg::CFG_INDEX_W'(i)))
            begin
                alarm_reg[i] <= rcal_pkg::alarm_word_t'(cfg_data);
            end
        end

        rcal_alarm_match u_match (
            .word (alarm_reg[i]),
            .now  (time_reg),
            .hit  (hit[i])
        );
    end

    rcal_advance u_advance (
        .cur (time_reg),
        .nxt (time_adv)
    );

    // Accept while the output register is empty or being drained
    assign in_ready    = !out_valid_reg || out_ch.ready;
    assign in_xfer     = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    // Pick the new time and alarm vector for this item
    always_comb
    begin
        if (in_ch.data.func == rcal_pkg::FUNC_SET)
        begin
            time_next.year         = in_ch.data.set_year;
            time_next.month        = in_ch.data.set_month;
            time_next.day_of_month = in_ch.data.set_day_of_month;
            time_next.day_of_week  = in_ch.data.set_day_of_week;
            time_next.hour         = in_ch.data.set_hour;
            time_next.minute       = in_ch.data.set_minute;
            time_next.second       = in_ch.data.set_second;
            fired                  = '0;
        end
        else
        begin
            time_next = time_adv;
            fired     = rcal_pkg::ALARM_FIRED_W'(hit);
        end
    end

    // Build the result and output handshake state
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_data_next.year         = time_next.year;
            out_data_next.month        = time_next.month;
            out_data_next.day_of_month = time_next.day_of_month;
            out_data_next.day_of_week  = time_next.day_of_week;
            out_data_next.hour         = time_next.hour;
            out_data_next.minute       = time_next.minute;
            out_data_next.second       = time_next.second;
            out_data_next.alarm_fired  = fired;
            out_valid_next             = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Calendar state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= RST_TIME;
        end
        else if (in_xfer)
        begin
            time_reg <= time_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

FILE: rtl/rcal_checker.sv
module rcal_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input rcal_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input rcal_pkg::out_item_t out_data
);

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("rcal: stalled result changed or dropped");

    // Never stall the input while the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("rcal: input stalled with empty output register");

    // Present a result the cycle after every input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid)
    else $error("rcal: no result after input transfer");

    // Set item: no alarm, loaded time except month and weekday
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_data.func == rcal_pkg::FUNC_SET) |=>
            (out_data.alarm_fired == '0)
            && (out_data.second == $past(in_data.set_second))
            && (out_data.minute == $past(in_data.set_minute))
            && (out_data.hour == $past(in_data.set_hour))
            && (out_data.day_of_month == $past(in_data.set_day_of_month))
            && (out_data.year == $past(in_data.set_year)))
    else $error("rcal: set item result mismatch");

endmodule

bind calendar_second_counter_with_alarms_core rcal_checker u_rcal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

FILE: tb/sv/calendar_checker.sv
// Watches both channels and the alarm write port, keeps its own calendar
// and alarm bank, and compares every output transfer with the oldest
// predicted time.
module calendar_checker
    import rcal_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rcal_in_if                     in_ch,
    rcal_out_if                    out_ch,
    output int                     mismatches,
    output int                     times_pending,
    output int                     results_seen,
    output int                     alarm_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    cal_time_t   clock_now;
    alarm_word_t alarm_bank [CFG_COUNT];
    out_item_t   pending_times [$];

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(logic [MONTH_W-1:0] m,
                                               logic [YEAR_W-1:0] y);
        int unsigned days;
        case (m)
            MONTH_FEB: days = leap_year(32'(y)) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 30;
            default: days = 31;
        endcase
        return days;
    endfunction

    // An alarm hits when enabled and every field is wild or equal
    function automatic bit alarm_hit(alarm_word_t w, cal_time_t t);
        return w.enable
            && (w.wild_second       || w.second       == t.second)
            && (w.wild_minute       || w.minute       == t.minute)
            && (w.wild_hour         || w.hour         == t.hour)
            && (w.wild_day_of_week  || w.day_of_week  == t.day_of_week)
            && (w.wild_day_of_month || w.day_of_month == t.day_of_month)
            && (w.wild_month        || w.month        == t.month)
            && (w.wild_year         || w.year         == t.year);
    endfunction

    // Advance the calendar by one second, rippling carries upward
    function automatic void add_second();
        int unsigned dow;
        int unsigned dom;
        int unsigned mon;
        int unsigned len;
        if (clock_now.second < SECOND_LAST)
        begin
            clock_now.second = clock_now.second + 1'b1;
            return;
        end
        clock_now.second = '0;
        if (clock_now.minute < MINUTE_LAST)
        begin
            clock_now.minute = clock_now.minute + 1'b1;
            return;
        end
        clock_now.minute = '0;
        if (clock_now.hour < HOUR_LAST)
        begin
            clock_now.hour = clock_now.hour + 1'b1;
            return;
        end
        clock_now.hour = '0;
        dow = 32'(clock_now.day_of_week) + 1;
        if (dow > 32'(DOW_LAST))
            dow = 32'(DOW_FIRST);
        clock_now.day_of_week = DOW_W'(dow);
        len = month_days(clock_now.month, clock_now.year);
        dom = 32'(clock_now.day_of_month) + 1;
        if (dom > len)
        begin
            dom = 32'(DOM_FIRST);
            mon = 32'(clock_now.month) + 1;
            if (mon > 32'(MONTH_LAST))
            begin
                mon = 32'(MONTH_FIRST);
                clock_now.year = clock_now.year + 1'b1;
            end
            clock_now.month = MONTH_W'(mon);
        end
        clock_now.day_of_month = DOM_W'(dom);
    endfunction

    // Apply one input item and return the time it should report
    function automatic out_item_t step_calendar(in_item_t it);
        out_item_t                r;
        logic [ALARM_FIRED_W-1:0] fired;
        int                       i;
        fired = '0;
        if (it.func == FUNC_SET)
        begin
            clock_now.year         = it.set_year;
            clock_now.month        = it.set_month;
            clock_now.day_of_month = it.set_day_of_month;
            clock_now.day_of_week  = it.set_day_of_week;
            clock_now.hour         = it.set_hour;
            clock_now.minute       = it.set_minute;
            clock_now.second       = it.set_second;
        end
        else
        begin
            for (i = 0; i < NUM_ALARMS && i < CFG_COUNT; i++)
                if (alarm_hit(alarm_bank[i], clock_now))
                    fired[i] = 1'b1;
            add_second();
        end
        r.year         = clock_now.year;
        r.month        = clock_now.month;
        r.day_of_month = clock_now.day_of_month;
        r.day_of_week  = clock_now.day_of_week;
        r.hour         = clock_now.hour;
        r.minute       = clock_now.minute;
        r.second       = clock_now.second;
        r.alarm_fired  = fired;
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch on %s at result %0d: expected %0d, got %0d",
                         field, results_seen, want, got);
        end
    endtask

    // Compare one output transfer with the oldest predicted time
    task automatic check_time(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (pending_times.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected result %0d: %p", results_seen, got);
            return;
        end
        want = pending_times.pop_front();
        alarm_hits += $countones(want.alarm_fired);
        flag_field("year",         16'(want.year),         16'(got.year));
        flag_field("month",        16'(want.month),        16'(got.month));
        flag_field("day_of_month", 16'(want.day_of_month), 16'(got.day_of_month));
        flag_field("day_of_week",  16'(want.day_of_week),  16'(got.day_of_week));
        flag_field("hour",         16'(want.hour),         16'(got.hour));
        flag_field("minute",       16'(want.minute),       16'(got.minute));
        flag_field("second",       16'(want.second),       16'(got.second));
        flag_field("alarm_fired",  16'(want.alarm_fired),  16'(got.alarm_fired));
    endtask

    // Check results first, then track alarm writes, then predict new items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_now.year         = RST_YEAR;
            clock_now.month        = RST_MONTH;
            clock_now.day_of_month = RST_DOM;
            clock_now.day_of_week  = RST_DOW;
            clock_now.hour         = RST_HOUR;
            clock_now.minute       = RST_MINUTE;
            clock_now.second       = RST_SECOND;
            for (int i = 0; i < CFG_COUNT; i++)
                alarm_bank[i] = '0;
            pending_times.delete();
            mismatches    = 0;
            times_pending = 0;
            results_seen  = 0;
            alarm_hits    = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_time(out_ch.data);
            if (cfg_we && 32'(cfg_index) < CFG_COUNT)
                alarm_bank[cfg_index] = cfg_data;
            if (in_ch.valid && in_ch.ready)
                pending_times.push_back(step_calendar(in_ch.data));
            times_pending = pending_times.size();
        end
    end

endmodule

FILE: tb/sv/calendar_second_counter_with_alarms_core_tb.sv
module calendar_second_counter_with_alarms_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcal_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rcal_in_if  in_ch ();
    rcal_out_if out_ch ();

    int mismatches;
    int times_pending;
    int results_seen;
    int alarm_hits;

    int cycles      = 0;
    int stall_left  = 0;
    int drain_roll  = 0;
    int items_sent  = 0;
    int sets_sent   = 0;
    int alarm_loads = 0;
    bit steady      = 1'b0;

    calendar_second_counter_with_alarms_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    calendar_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .mismatches    (mismatches),
        .times_pending (times_pending),
        .results_seen  (results_seen),
        .alarm_hits    (alarm_hits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, times_pending);
            $display("simulation failed");
            $finish;
        end
    end

    // Drain side: mostly ready, short stalls, rare long ones; ready when steady
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready = 1'b0;
        end
        else if (steady)
            out_ch.ready = 1'b1;
        else
        begin
            drain_roll = $urandom_range(0, 99);
            if (drain_roll < 70)
                out_ch.ready = 1'b1;
            else if (drain_roll < 95)
                out_ch.ready = 1'b0;
            else
            begin
                stall_left   = $urandom_range(4, 40);
                out_ch.ready = 1'b0;
            end
        end
    end

    function automatic cal_time_t clock_at(int y, int mo, int d, int w, int h,
                                           int mi, int s);
        cal_time_t t;
        t.year         = YEAR_W'(y);
        t.month        = MONTH_W'(mo);
        t.day_of_month = DOM_W'(d);
        t.day_of_week  = DOW_W'(w);
        t.hour         = HOUR_W'(h);
        t.minute       = MINUTE_W'(mi);
        t.second       = SECOND_W'(s);
        return t;
    endfunction

    function automatic in_item_t set_from(cal_time_t t);
        in_item_t it;
        it.func             = FUNC_SET;
        it.set_year         = t.year;
        it.set_month        = t.month;
        it.set_day_of_month = t.day_of_month;
        it.set_day_of_week  = t.day_of_week;
        it.set_hour         = t.hour;
        it.set_minute       = t.minute;
        it.set_second       = t.second;
        return it;
    endfunction

    // Random bits in every field but func; ticks carry junk set fields too
    function automatic in_item_t noise_item(func_t f);
        logic [63:0] bits;
        in_item_t    it;
        bits    = {$urandom, $urandom};
        it      = bits[$bits(in_item_t)-1:0];
        it.func = f;
        return it;
    endfunction

    function automatic alarm_word_t alarm_for(bit en, logic [6:0] wild, cal_time_t t);
        alarm_word_t w;
        w.enable            = en;
        w.wild_second       = wild[0];
        w.wild_minute       = wild[1];
        w.wild_hour         = wild[2];
        w.wild_day_of_week  = wild[3];
        w.wild_day_of_month = wild[4];
        w.wild_month        = wild[5];
        w.wild_year         = wild[6];
        w.second            = t.second;
        w.minute            = t.minute;
        w.hour              = t.hour;
        w.day_of_week       = t.day_of_week;
        w.day_of_month      = t.day_of_month;
        w.month             = t.month;
        w.year              = t.year;
        return w;
    endfunction

    // Random calendar time, biased toward the ends of minutes, days and months
    function automatic cal_time_t near_rollover();
        cal_time_t t;
        case ($urandom_range(0, 5))
            0: t.year = YEAR_W'(1900);
            1: t.year = YEAR_W'(2000);
            2: t.year = YEAR_W'(2100);
            3: t.year = YEAR_W'(4095);
            default: t.year = YEAR_W'($urandom_range(0, 4095));
        endcase
        t.month        = MONTH_W'($urandom_range(1, 12));
        t.day_of_month = DOM_W'($urandom_range(0, 1) != 0 ? $urandom_range(27, 31)
                                                          : $urandom_range(1, 31));
        t.day_of_week  = DOW_W'($urandom_range(1, 7));
        t.hour         = HOUR_W'($urandom_range(0, 1) != 0 ? 23 : $urandom_range(0, 23));
        t.minute       = MINUTE_W'($urandom_range(0, 1) != 0 ? 59 : $urandom_range(0, 59));
        t.second       = SECOND_W'($urandom_range(0, 2) != 0 ? $urandom_range(50, 59)
                                                             : $urandom_range(0, 59));
        return t;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Offer one item and hold it until the transfer; enter and leave at negedge
    task automatic send_item(input in_item_t it);
        repeat (pick_gap()) @(negedge clk);
        in_ch.data  = it;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        if (it.func == FUNC_SET)
            sets_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_item(noise_item(FUNC_TICK));
    endtask

    task automatic write_alarm(input int idx, input alarm_word_t w);
        cfg_we    = 1'b1;
        cfg_index = CFG_INDEX_W'(idx);
        cfg_data  = w;
        @(negedge clk);
        cfg_we    = 1'b0;
        alarm_loads++;
    endtask

    task automatic wait_idle();
        while (times_pending != 0)
            @(negedge clk);
    endtask

    // Aimed at one time, random wildcards, some noise; phase 1 zeros, 2 ones
    task automatic load_alarm_bank(input int phase, input cal_time_t aim);
        alarm_word_t w;
        logic [63:0] bits;
        int          i;
        for (i = 0; i < CFG_COUNT; i++)
        begin
            if (phase == 1)
                w = '0;
            else if (phase == 2)
                w = '1;
            else
            begin
                w = alarm_for($urandom_range(0, 5) != 0, 7'($urandom), aim);
                if ($urandom_range(0, 4) == 0)
                begin
                    bits = {$urandom, $urandom};
                    w    = bits[ALARM_W-1:0];
                end
            end
            write_alarm(i, w);
        end
    endtask

    initial
    begin
        alarm_word_t bank [CFG_COUNT];
        cal_time_t   aim;
        cal_time_t   t;
        int          start;
        int          lead;
        int          roll;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // First tick straight from reset, all alarms clear
        send_item(noise_item(FUNC_TICK));
        wait_idle();

        // Catch-all, exact new-millennium, disabled catch-all, end of year 4095
        bank[0] = alarm_for(1'b1, 7'h7F, '0);
        bank[1] = alarm_for(1'b1, 7'h00, clock_at(2000, 1, 1, 7, 0, 0, 0));
        bank[2] = alarm_for(1'b0, 7'h7F, '0);
        bank[3] = alarm_for(1'b1, 7'h01, clock_at(4095, 12, 31, 7, 23, 59, 0));
        for (int i = 0; i < CFG_COUNT; i++)
            write_alarm(i, bank[i]);

        // Year rollover into a century leap year, then the exact alarm
        send_item(set_from(clock_at(1999, 12, 31, 6, 23, 59, 59)));
        run_ticks(2);
        // Leap day ends in 2000, no leap day in 1900, leap day reached in 2024
        send_item(set_from(clock_at(2000, 2, 29, 3, 23, 59, 59)));
        run_ticks(1);
        send_item(set_from(clock_at(1900, 2, 28, 4, 23, 59, 59)));
        run_ticks(1);
        send_item(set_from(clock_at(2024, 2, 28, 4, 23, 59, 59)));
        run_ticks(1);
        // Second 58 steps without carry, then a 30-day month ends
        send_item(set_from(clock_at(2023, 4, 30, 1, 23, 59, 58)));
        run_ticks(2);
        // Year wraps to zero and weekday wraps to Sunday
        send_item(set_from(clock_at(4095, 12, 31, 7, 23, 59, 59)));
        run_ticks(1);
        // Out-of-range fields loaded unchecked: month zero, weekday zero
        send_item(set_from(clock_at(0, 0, 31, 0, 31, 63, 63)));
        run_ticks(1);
        // All ones: month 15 carries into a new year
        send_item(set_from(clock_at(4095, 15, 31, 7, 31, 63, 63)));
        run_ticks(1);
        // Day 31 in April, day zero in February
        send_item(set_from(clock_at(2023, 4, 31, 2, 23, 59, 59)));
        run_ticks(1);
        send_item(set_from(clock_at(2001, 2, 0, 5, 23, 59, 59)));
        run_ticks(1);

        // Random phases, each with its own alarm bank
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            steady = (phase == 3);
            aim    = near_rollover();
            load_alarm_bank(phase, aim);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                begin
                    send_item(set_from(near_rollover()));
                    run_ticks($urandom_range(1, 12));
                end
                else if (roll < 50)
                begin
                    send_item(set_from(near_rollover()));
                    run_ticks($urandom_range(40, 90));
                end
                else if (roll < 75)
                begin
                    // Land at or just before the alarm time and tick through it
                    lead = $urandom_range(0, 4);
                    t    = aim;
                    if (32'(t.second) >= lead)
                        t.second = t.second - SECOND_W'(lead);
                    send_item(set_from(t));
                    run_ticks(lead + 2);
                end
                else if (roll < 88)
                    run_ticks($urandom_range(1, 20));
                else
                begin
                    send_item(noise_item(FUNC_SET));
                    run_ticks($urandom_range(0, 3));
                end
            end
        end
        steady = 1'b0;

        // Drain, then let the registered output settle
        wait_idle();
        repeat (4) @(negedge clk);

        $display("covered %0d items (%0d time loads) over %0d alarm writes",
                 items_sent, sets_sent, alarm_loads);
        $display("%0d results checked, %0d alarm hits predicted",
                 results_seen, alarm_hits);
        if (mismatches == 0 && times_pending == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, times_pending);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/rcal_pkg.sv
rtl/rcal_if.sv
rtl/rcal_alarm_match.sv
rtl/rcal_advance.sv
rtl/calendar_second_counter_with_alarms_core.sv
rtl/rcal_checker.sv
tb/sv/calendar_checker.sv
tb/sv/calendar_second_counter_with_alarms_core_tb.sv
